[rtl/ifpd_pkg.sv]
// Shared types, constants and helper functions for the IMU FIFO pattern demux.
package ifpd_pkg;

    // Design sizing
    localparam int NUM_SENSORS = 3;    // 2..3 sensors share the FIFO
    localparam int COUNT_BITS  = 8;    // width of the per-pattern count per sensor
    localparam int SLOT_W      = 2;    // slot index, wide enough for the "none" code
    localparam int DROP_W      = 4;
    localparam int CFG_CNT_W   = 8;
    localparam int WORD_W      = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // Sensor kinds as the host sees them
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_MAG   = 2'd2;

    // Pattern slots, in round-robin order
    localparam logic [SLOT_W-1:0] SLOT_GYRO  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_ACCEL = 2'd1;
    localparam logic [SLOT_W-1:0] NO_SLOT    = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ARM    = 1'b1;

    localparam logic STATUS_TAGGED        = 1'b0;
    localparam logic STATUS_EMPTY_PATTERN = 1'b1;

    // Register word indexes (paddr[3:2])
    localparam logic [1:0] REG_GYRO_PER_PATTERN  = 2'd0;
    localparam logic [1:0] REG_ACCEL_PER_PATTERN = 2'd1;
    localparam logic [1:0] REG_MAG_PER_PATTERN   = 2'd2;
    localparam logic [1:0] REG_DISCARD           = 2'd3;

    localparam logic [DROP_W-1:0] DISCARD_RESET = 4'd2;

    typedef logic        [1:0]            kind_t;
    typedef logic        [SLOT_W-1:0]     slot_t;
    typedef logic        [COUNT_BITS-1:0] count_t;
    typedef logic        [DROP_W-1:0]     drop_t;
    typedef logic signed [WORD_W-1:0]     word_t;

    typedef struct packed {
        logic [CFG_CNT_W-1:0] gyro_per_pattern;
        logic [CFG_CNT_W-1:0] accel_per_pattern;
        logic [CFG_CNT_W-1:0] mag_per_pattern;
        drop_t                discard_after_change;
    } cfg_regs_t;

    typedef struct packed {
        logic  opcode;
        kind_t sensor_choice;
        word_t axis_x_raw;
        word_t axis_y_raw;
        word_t axis_z_raw;
    } in_item_t;

    typedef struct packed {
        logic  status;
        kind_t sensor_kind;
        word_t out_x;
        word_t out_y;
        word_t out_z;
    } out_item_t;

    function automatic kind_t slot_kind(input slot_t slot);
        kind_t kind;
        unique case (slot)
            SLOT_GYRO:  kind = KIND_GYRO;
            SLOT_ACCEL: kind = KIND_ACCEL;
            default:    kind = KIND_MAG;
        endcase
        return kind;
    endfunction

    // Pattern count for a slot, taken in its low COUNT_BITS bits
    function automatic count_t slot_count(input cfg_regs_t cfg, input slot_t slot);
        count_t cnt;
        unique case (slot)
            SLOT_GYRO:  cnt = COUNT_BITS'(cfg.gyro_per_pattern);
            SLOT_ACCEL: cnt = COUNT_BITS'(cfg.accel_per_pattern);
            default:    cnt = COUNT_BITS'(cfg.mag_per_pattern);
        endcase
        return cnt;
    endfunction

endpackage

[rtl/ifpd_channels.sv]
// Valid/ready channel interfaces for FIFO samples and tagged results.
interface ifpd_sample_if import ifpd_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  opcode;
    kind_t sensor_choice;
    word_t axis_x_raw;
    word_t axis_y_raw;
    word_t axis_z_raw;

    modport source (
        output valid, opcode, sensor_choice, axis_x_raw, axis_y_raw, axis_z_raw,
        input  ready
    );
    modport sink (
        input  valid, opcode, sensor_choice, axis_x_raw, axis_y_raw, axis_z_raw,
        output ready
    );
endinterface

interface ifpd_result_if import ifpd_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  status;
    kind_t sensor_kind;
    word_t out_x;
    word_t out_y;
    word_t out_z;

    modport source (
        output valid, status, sensor_kind, out_x, out_y, out_z,
        input  ready
    );
    modport sink (
        input  valid, status, sensor_kind, out_x, out_y, out_z,
        output ready
    );
endinterface

[rtl/imu_fifo_pattern_demux.sv]
// Top level of the IMU FIFO pattern demux: input register, pattern core, result register.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+----------------------------------------------
//  samples  | in  | valid/ready       | opcode, sensor_choice, axis_x/y/z_raw
//  results  | out | valid/ready       | status, sensor_kind, out_x/y/z
//  apb      | in  | psel/penable      | paddr[3:0], pwdata, prdata (pready tied high)
//
// One transaction per cycle sustained while results.ready is high: a sample is captured
// in the input register, tagged by the pattern core when the result register is free or
// draining, and lands in the result register, where result valid rises if a result is made.
// Reset clears pattern counts, discard counters and the last-served slot (next is gyro).
// A stalled result holds the core; samples.ready drops only while both registers are full
// and results.ready is low.
module imu_fifo_pattern_demux import ifpd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    ifpd_sample_if.sink       samples,
    ifpd_result_if.source     results
);

    cfg_regs_t cfg;
    in_item_t  in_item_reg;
    in_item_t  in_item_next;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t core_result;
    logic      core_has_result;
    logic      fire;
    logic      take_in;

    ifpd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifpd_pattern_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (in_item_reg),
        .cfg        (cfg),
        .has_result (core_has_result),
        .result     (core_result)
    );

    // the held item is processed when the result register is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || fire;
    assign take_in       = samples.valid && samples.ready;

    always_comb
    begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_item_next.opcode        = samples.opcode;
            in_item_next.sensor_choice = samples.sensor_choice;
            in_item_next.axis_x_raw    = samples.axis_x_raw;
            in_item_next.axis_y_raw    = samples.axis_y_raw;
            in_item_next.axis_z_raw    = samples.axis_z_raw;
            in_valid_next              = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_item_next  = core_result;
            out_valid_next = core_has_result;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = out_item_reg.status;
    assign results.sensor_kind = out_item_reg.sensor_kind;
    assign results.out_x       = out_item_reg.out_x;
    assign results.out_y       = out_item_reg.out_y;
    assign results.out_z       = out_item_reg.out_z;

endmodule

[rtl/ifpd_apb_regs.sv]
// APB configuration registers: per-pattern counts and discard depth.
module ifpd_apb_regs import ifpd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_regs_t         cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;
    logic      wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_GYRO_PER_PATTERN:  cfg_next.gyro_per_pattern  = pwdata[CFG_CNT_W-1:0];
                REG_ACCEL_PER_PATTERN: cfg_next.accel_per_pattern = pwdata[CFG_CNT_W-1:0];
                REG_MAG_PER_PATTERN:   cfg_next.mag_per_pattern   = pwdata[CFG_CNT_W-1:0];
                REG_DISCARD:           cfg_next.discard_after_change = pwdata[DROP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GYRO_PER_PATTERN:  prdata = DATA_W'(cfg_reg.gyro_per_pattern);
            REG_ACCEL_PER_PATTERN: prdata = DATA_W'(cfg_reg.accel_per_pattern);
            REG_MAG_PER_PATTERN:   prdata = DATA_W'(cfg_reg.mag_per_pattern);
            REG_DISCARD:           prdata = DATA_W'(cfg_reg.discard_after_change);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gyro_per_pattern     <= '0;
            cfg_reg.accel_per_pattern    <= '0;
            cfg_reg.mag_per_pattern      <= '0;
            cfg_reg.discard_after_change <= DISCARD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/ifpd_pattern_core.sv]
// Pattern state, round-robin slot pick and per-sensor discard counters.
module ifpd_pattern_core import ifpd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_regs_t cfg,
    output logic      has_result,
    output out_item_t result
);

    count_t left_reg    [NUM_SENSORS];
    count_t left_next   [NUM_SENSORS];
    drop_t  drop_reg    [NUM_SENSORS];
    drop_t  drop_next   [NUM_SENSORS];
    slot_t  last_reg;
    slot_t  last_next;

    count_t reload_left [NUM_SENSORS];
    count_t eff_left    [NUM_SENSORS];
    slot_t  eff_last;
    slot_t  start_slot;
    slot_t  pick;
    logic   found;
    logic   empty;
    logic   drop_hit;
    kind_t  kind;
    logic   is_arm;

    assign is_arm = (item.opcode == OP_ARM);

    always_comb
    begin
        empty = 1'b1;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            reload_left[i] = slot_count(cfg, SLOT_W'(i));
            if (left_reg[i] != '0)
                empty = 1'b0;
        end
        // a used-up pattern reloads before the pick
        if (empty)
        begin
            eff_left = reload_left;
            eff_last = NO_SLOT;
        end
        else
        begin
            eff_left = left_reg;
            eff_last = last_reg;
        end
    end

    // Round-robin search starting after the last served slot
    always_comb
    begin
        logic [SLOT_W:0] cand;
        if (eff_last == NO_SLOT || eff_last == SLOT_W'(NUM_SENSORS - 1))
            start_slot = '0;
        else
            start_slot = eff_last + 1'b1;
        found = 1'b0;
        pick  = '0;
        for (int k = 0; k < NUM_SENSORS; k++)
        begin
            cand = (SLOT_W+1)'(start_slot) + (SLOT_W+1)'(k);
            if (cand >= (SLOT_W+1)'(NUM_SENSORS))
                cand = cand - (SLOT_W+1)'(NUM_SENSORS);
            if (!found && eff_left[cand[SLOT_W-1:0]] != '0)
            begin
                found = 1'b1;
                pick  = cand[SLOT_W-1:0];
            end
        end
        kind     = slot_kind(pick);
        drop_hit = (drop_reg[kind] != '0);
    end

    always_comb
    begin
        left_next = left_reg;
        drop_next = drop_reg;
        last_next = last_reg;
        if (fire)
        begin
            if (is_arm)
            begin
                if (item.sensor_choice < SLOT_W'(NUM_SENSORS))
                    drop_next[item.sensor_choice] = cfg.discard_after_change;
                left_next = reload_left;
                last_next = NO_SLOT;
            end
            else if (found)
            begin
                left_next       = eff_left;
                left_next[pick] = eff_left[pick] - 1'b1;
                last_next       = pick;
                if (drop_hit)
                    drop_next[kind] = drop_reg[kind] - 1'b1;
            end
            else
            begin
                left_next = eff_left;
                last_next = eff_last;
            end
        end
    end

    always_comb
    begin
        has_result = !is_arm && (!found || !drop_hit);
        if (!found)
        begin
            result.status      = STATUS_EMPTY_PATTERN;
            result.sensor_kind = '0;
            result.out_x       = '0;
            result.out_y       = '0;
            result.out_z       = '0;
        end
        else
        begin
            result.status      = STATUS_TAGGED;
            result.sensor_kind = kind;
            result.out_x       = item.axis_x_raw;
            result.out_y       = item.axis_y_raw;
            result.out_z       = item.axis_z_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                left_reg[i] <= '0;
                drop_reg[i] <= '0;
            end
            last_reg <= NO_SLOT;
        end
        else
        begin
            left_reg <= left_next;
            drop_reg <= drop_next;
            last_reg <= last_next;
        end
    end

endmodule
